// File: sv/assert_macros.svh
// Assertion macros shared by the vibration level classifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent assertion on clk, disabled while rst_n is low
`define VLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion checked in the cycle after a trigger
`define VLC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define VLC_ASSERT(label, prop, msg)
`define VLC_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// File: sv/vlc_pkg.sv
// Types and constants of the vibration level classifier
`default_nettype none
package vlc_pkg;
    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 16;
    localparam int PERSIST_W = 8;
    localparam int COUNT_W = 32;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_DANGER = 2'd2;
    localparam logic [1:0] LVL_RESERVED = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_WARNING = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DANGER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HYST = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERSIST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd4;

    localparam logic [PERSIST_W-1:0] RUN_MAX = 8'hFF;
    localparam logic [PERSIST_W-1:0] PERSIST_RESET = 8'd1;

    typedef struct packed {
        logic [THRESH_W-1:0]  warning;
        logic [THRESH_W-1:0]  danger;
        logic [THRESH_W-1:0]  hysteresis;
        logic [PERSIST_W-1:0] persistence;
        logic                 enable;
        logic                 valid;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         level;
        logic               changed;
        logic               decided;
        logic               config_valid;
        logic [COUNT_W-1:0] sample_total;
        logic [COUNT_W-1:0] change_total;
    } result_t;
endpackage
`default_nettype wire

// File: sv/vlc_cfg.sv
// Configuration registers and set-up check
`default_nettype none
module vlc_cfg
    import vlc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);
    logic [THRESH_W-1:0]  warning_reg;
    logic [THRESH_W-1:0]  danger_reg;
    logic [THRESH_W-1:0]  hyst_reg;
    logic [PERSIST_W-1:0] persist_reg;
    logic                 enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warning_reg <= '0;
            danger_reg  <= '0;
            hyst_reg    <= '0;
            persist_reg <= PERSIST_RESET;
            enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WARNING: warning_reg <= cfg_data;
                REG_DANGER:  danger_reg  <= cfg_data;
                REG_HYST:    hyst_reg    <= cfg_data;
                REG_PERSIST: persist_reg <= cfg_data[PERSIST_W-1:0];
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cfg.warning     = warning_reg;
        cfg.danger      = danger_reg;
        cfg.hysteresis  = hyst_reg;
        cfg.persistence = persist_reg;
        cfg.enable      = enable_reg;
        cfg.valid       = (warning_reg != '0) && (danger_reg > warning_reg)
                          && (hyst_reg < warning_reg);
    end
endmodule
`default_nettype wire

// File: sv/vlc_classify.sv
// Level decision, candidate tracking and counters
`default_nettype none
`include "assert_macros.svh"
module vlc_classify
    import vlc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  cfg_t                            cfg,
    input  wire logic                       cfg_we,
    input  wire logic                       step,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output result_t                         res
);
    logic [1:0]           level_reg, level_next;
    logic [1:0]           cand_reg, cand_next;
    logic [PERSIST_W-1:0] run_reg, run_next;
    logic [COUNT_W-1:0]   samples_reg, samples_next;
    logic [COUNT_W-1:0]   changes_reg, changes_next;
    logic [THRESH_W-1:0]  mag;
    logic [THRESH_W-1:0]  warn_low;
    logic [THRESH_W-1:0]  dang_low;
    logic [1:0]           nxt;
    logic                 decided;
    logic                 changed;

    // only used when decided: sample non-negative, hysteresis below both thresholds
    assign mag      = {1'b0, sample[SAMPLE_W-2:0]};
    assign warn_low = cfg.warning - cfg.hysteresis;
    assign dang_low = cfg.danger - cfg.hysteresis;
    assign decided  = cfg.enable && cfg.valid && !sample[SAMPLE_W-1];

    always_comb
    begin
        unique case (level_reg)
            LVL_NORMAL:  nxt = (mag >= cfg.warning) ? LVL_WARNING : LVL_NORMAL;
            LVL_WARNING:
            begin
                if (mag >= cfg.danger)
                    nxt = LVL_DANGER;
                else if (mag <= warn_low)
                    nxt = LVL_NORMAL;
                else
                    nxt = LVL_WARNING;
            end
            LVL_DANGER:  nxt = (mag <= dang_low) ? LVL_WARNING : LVL_DANGER;
            default:     nxt = LVL_NORMAL;
        endcase
    end

    always_comb
    begin
        level_next = level_reg;
        cand_next  = cand_reg;
        run_next   = run_reg;
        changed    = 1'b0;
        if (decided)
        begin
            if (nxt == level_reg)
            begin
                cand_next = level_reg;
                run_next  = '0;
            end
            else
            begin
                if (nxt != cand_reg)
                begin
                    cand_next = nxt;
                    run_next  = 8'd1;
                end
                else if (run_reg != RUN_MAX)
                    run_next = run_reg + 8'd1;
                if (run_next >= cfg.persistence)
                begin
                    level_next = cand_next;
                    run_next   = '0;
                    changed    = 1'b1;
                end
            end
        end
        samples_next = samples_reg + 32'd1;
        changes_next = changed ? changes_reg + 32'd1 : changes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LVL_NORMAL;
            cand_reg    <= LVL_NORMAL;
            run_reg     <= '0;
            samples_reg <= '0;
            changes_reg <= '0;
        end
        else if (cfg_we)
        begin
            cand_reg <= level_reg;
            run_reg  <= '0;
        end
        else if (step)
        begin
            level_reg   <= level_next;
            cand_reg    <= cand_next;
            run_reg     <= run_next;
            samples_reg <= samples_next;
            changes_reg <= changes_next;
        end
    end

    always_comb
    begin
        res.level        = level_next;
        res.changed      = changed;
        res.decided      = decided;
        res.config_valid = cfg.valid;
        res.sample_total = samples_next;
        res.change_total = changes_next;
    end

    `VLC_ASSERT(a_level_legal, level_reg != LVL_RESERVED, "level reached reserved code")
    `VLC_ASSERT(a_change_needs_decision, !changed || decided, "change without decision")
    `VLC_ASSERT_NEXT(a_idle_level_holds, step && !decided, $stable(level_reg),
        "level moved on undecided sample")
    `VLC_ASSERT_NEXT(a_cfg_clears_run, cfg_we, run_reg == '0,
        "candidate run not cleared by config write")
endmodule
`default_nettype wire

// File: sv/vibration_level_classifier_top.sv
// Top level: input register, classifier, result register and handshakes
// Path: a taken request waits in the input register until the result register is free; out_valid rises as it loads.
// Throughput: one request per cycle while out_stall is low; the input register advances whenever the result
// register is empty or being taken, so stall on the input follows stall on the output.
// Reset: rst_n asynchronous, active low; clears level, candidate, counters, valids
// and loads configuration reset values (persistence 1, all else 0).
`default_nettype none
`include "assert_macros.svh"
module vibration_level_classifier_top
    import vlc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      level,
    output logic                            changed,
    output logic                            decided,
    output logic                            config_valid,
    output logic [COUNT_W-1:0]              sample_total,
    output logic [COUNT_W-1:0]              change_total,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [REG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    result_t                    res_reg;
    result_t                    res;
    cfg_t                       cfg;
    logic                       step;
    logic                       cfg_we;
    logic                       in_take;

    assign step      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step;
    assign in_take   = in_valid && !in_stall;
    // writes wait until no request is held or offered
    assign cfg_ready = !in_valid_reg && !in_valid;
    assign cfg_we    = cfg_valid && cfg_ready;

    vlc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vlc_classify u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_we (cfg_we),
        .step   (step),
        .sample (sample_reg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (in_take)
                sample_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign level        = res_reg.level;
    assign changed      = res_reg.changed;
    assign decided      = res_reg.decided;
    assign config_valid = res_reg.config_valid;
    assign sample_total = res_reg.sample_total;
    assign change_total = res_reg.change_total;

    `VLC_ASSERT_NEXT(a_step_loads_out, step, out_valid_reg, "result lost after step")
    `VLC_ASSERT(a_no_cfg_in_flight, !(cfg_we && in_valid_reg), "config write with request held")
    `VLC_ASSERT_NEXT(a_count_tracks_step, step && out_valid_reg,
        sample_total == $past(sample_total) + 32'd1, "sample count skipped")
endmodule
`default_nettype wire
